>>> rtl/bmprgb_pkg.sv
// shared types and constants for the bmp byte stream to rgb565 decoder
`timescale 1ns / 1ps
package bmprgb_pkg;

  localparam int unsigned MaxDimension = 4096;
  localparam int unsigned MaxInfoHeader = 124;
  localparam int unsigned MinInfoHeader = 40;

  localparam logic [7:0] MAGIC_B = 8'h42;
  localparam logic [7:0] MAGIC_M = 8'h4D;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MAGIC     = 3'd1,
    ERR_HDR_SIZE  = 3'd2,
    ERR_WIDTH     = 3'd3,
    ERR_HEIGHT    = 3'd4,
    ERR_FORMAT    = 3'd5,
    ERR_TRUNCATED = 3'd6
  } err_t;

  // result tdata, last field in the lowest bits
  typedef struct packed {
    logic [2:0]  pad;
    logic [12:0] image_height;
    logic [12:0] image_width;
    logic [11:0] row;
    logic [11:0] column;
    logic [15:0] color;
    err_t        error_code;
  } out_data_t;

  typedef struct packed {
    kind_t     kind;
    out_data_t data;
    logic      image_complete;
  } result_t;

endpackage

>>> rtl/bmprgb_decode.sv
// bmp header parser and pixel walker, one stream byte per step
`timescale 1ns / 1ps
module bmprgb_decode
  import bmprgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] stream_byte,
  input  logic       end_of_stream,
  output logic       res_valid,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_PIXEL  = 3'd2,
    PH_PAD    = 3'd3,
    PH_HALT   = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [23:0] shift_r, shift_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [6:0]  ihs_r, ihs_nxt;
  logic [12:0] width_r, width_nxt;
  logic [12:0] height_r, height_nxt;
  logic        bottom_up_r, bottom_up_nxt;
  logic [15:0] bit_count_r, bit_count_nxt;
  logic        four_r, four_nxt;
  logic [11:0] col_r, col_nxt;
  logic [11:0] row_r, row_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic [4:0]  blue_r, blue_nxt;
  logic [5:0]  green_r, green_nxt;

  logic [31:0] acc;
  logic [31:0] mag;
  logic [32:0] pos_inc;
  logic [12:0] col_inc;
  logic [12:0] row_inc;
  logic [1:0]  last_k;
  logic [1:0]  row_pad;
  logic [11:0] dst_row;
  err_t        err;
  logic        finished;
  logic        have_pixel;
  logic [15:0] px_color;

  // little-endian field shifter, only the upper three bytes carry over
  assign acc     = {stream_byte, shift_r};
  assign mag     = acc[31] ? (32'd0 - acc) : acc;
  assign pos_inc = {1'b0, pos_r} + 33'd1;
  assign col_inc = {1'b0, col_r} + 13'd1;
  assign row_inc = {1'b0, row_r} + 13'd1;
  assign last_k  = four_r ? 2'd3 : 2'd2;
  // stride padding: only 24-bit rows can end off a four-byte boundary
  assign row_pad = four_r ? 2'd0 : (2'd0 - (width_r[1:0] * 2'd3));
  assign dst_row = bottom_up_r ? 12'(height_r - 13'd1 - {1'b0, row_r}) : row_r;
  assign px_color = {stream_byte[7:3], green_r, blue_r};

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    shift_nxt     = shift_r;
    offset_nxt    = offset_r;
    ihs_nxt       = ihs_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    bottom_up_nxt = bottom_up_r;
    bit_count_nxt = bit_count_r;
    four_nxt      = four_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    bip_nxt       = bip_r;
    pad_nxt       = pad_r;
    blue_nxt      = blue_r;
    green_nxt     = green_r;
    err           = ERR_NONE;
    finished      = 1'b0;
    have_pixel    = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        shift_nxt = acc[31:8];
        pos_nxt   = pos_inc[31:0];
        if ((pos_r == 32'd0 && stream_byte != MAGIC_B) ||
            (pos_r == 32'd1 && stream_byte != MAGIC_M)) begin
          err = ERR_MAGIC;
        end
        if (pos_r == 32'd13) offset_nxt = acc;
        if (pos_r == 32'd17) begin
          if (acc < 32'(MinInfoHeader) || acc > 32'(MaxInfoHeader)) err = ERR_HDR_SIZE;
          else ihs_nxt = acc[6:0];
        end
        if (pos_r == 32'd21) begin
          if (acc[31] || acc == 32'd0 || acc > 32'(MaxDimension)) err = ERR_WIDTH;
          else width_nxt = acc[12:0];
        end
        if (pos_r == 32'd25) begin
          bottom_up_nxt = ~acc[31];
          if (mag == 32'd0 || mag > 32'(MaxDimension)) err = ERR_HEIGHT;
          else height_nxt = mag[12:0];
        end
        if (pos_r == 32'd29) bit_count_nxt = acc[31:16];
        if (pos_r == 32'd33) begin
          if (bit_count_r == 16'd24 && acc == 32'd0) four_nxt = 1'b0;
          else if (bit_count_r == 16'd32 && (acc == 32'd0 || acc == 32'd3)) four_nxt = 1'b1;
          else err = ERR_FORMAT;
        end
        // last byte of the info header
        if (err == ERR_NONE && pos_r >= 32'd17 && pos_r == 32'd13 + {25'd0, ihs_r}) begin
          if ({1'b0, offset_r} > pos_inc) begin
            phase_nxt = PH_SKIP;
          end else begin
            phase_nxt = PH_PIXEL;
            col_nxt   = '0;
            row_nxt   = '0;
            bip_nxt   = '0;
            pad_nxt   = '0;
          end
        end
      end
      PH_SKIP: begin
        pos_nxt = pos_inc[31:0];
        if (pos_inc >= {1'b0, offset_r}) begin
          phase_nxt = PH_PIXEL;
          col_nxt   = '0;
          row_nxt   = '0;
          bip_nxt   = '0;
          pad_nxt   = '0;
        end
      end
      PH_PIXEL: begin
        if (bip_r == 2'd0) blue_nxt = stream_byte[7:3];
        if (bip_r == 2'd1) green_nxt = stream_byte[7:2];
        if (bip_r == 2'd2) have_pixel = 1'b1;
        if (bip_r >= last_k) begin
          bip_nxt = 2'd0;
          col_nxt = col_inc[11:0];
          if (col_inc >= width_r) begin
            col_nxt = '0;
            if (row_pad != 2'd0) begin
              phase_nxt = PH_PAD;
              pad_nxt   = row_pad;
            end else begin
              row_nxt = row_inc[11:0];
              if (row_inc >= height_r) begin
                phase_nxt = PH_HALT;
                finished  = 1'b1;
              end
            end
          end
        end else begin
          bip_nxt = bip_r + 2'd1;
        end
      end
      PH_PAD: begin
        pad_nxt = pad_r - 2'd1;
        if (pad_nxt == 2'd0) begin
          row_nxt   = row_inc[11:0];
          phase_nxt = PH_PIXEL;
          if (row_inc >= height_r) begin
            phase_nxt = PH_HALT;
            finished  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // early end of file takes the place of whatever this byte would give
    if (err == ERR_NONE && end_of_stream && phase_r != PH_HALT && !finished) begin
      err = ERR_TRUNCATED;
    end
    if (err != ERR_NONE) phase_nxt = PH_HALT;
  end

  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (err != ERR_NONE) begin
      res_valid           = 1'b1;
      res.kind            = KIND_ERROR;
      res.data.error_code = err;
    end else if (have_pixel) begin
      res_valid       = 1'b1;
      res.kind        = KIND_PIXEL;
      res.data.color  = px_color;
      res.data.column = col_r;
      res.data.row    = dst_row;
      if (finished) begin
        res.data.image_width  = width_r;
        res.data.image_height = height_r;
        res.image_complete    = 1'b1;
      end
    end else if (finished) begin
      res_valid             = 1'b1;
      res.kind              = KIND_DONE;
      res.data.image_width  = width_r;
      res.data.image_height = height_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && end_of_stream)) begin
      phase_r     <= PH_HEADER;
      pos_r       <= '0;
      shift_r     <= '0;
      offset_r    <= '0;
      ihs_r       <= '0;
      width_r     <= '0;
      height_r    <= '0;
      bottom_up_r <= 1'b0;
      bit_count_r <= '0;
      four_r      <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      bip_r       <= '0;
      pad_r       <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      shift_r     <= shift_nxt;
      offset_r    <= offset_nxt;
      ihs_r       <= ihs_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      bottom_up_r <= bottom_up_nxt;
      bit_count_r <= bit_count_nxt;
      four_r      <= four_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      bip_r       <= bip_nxt;
      pad_r       <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
    end
  end

endmodule

>>> rtl/bmp_stream_to_rgb565.sv
// top level: bmp byte stream in, rgb565 pixel / done / error results out
`timescale 1ns / 1ps
// Takes a 24- or 32-bit uncompressed BMP file one byte per transfer and gives
// one result per pixel (rgb565 color, column, destination row), a done result
// after the last pixel or padding byte (unless that last pixel result flags
// image complete), or an error result. A byte passes an input register and the
// header/pixel logic, and its result lands in an output register; one byte is
// taken every cycle as long as the output side keeps up. A transfer with
// in_tlast ends the file and returns the decoder to its start state. After
// done or error, bytes up to in_tlast give no result. No clearing pass after
// reset.
module bmp_stream_to_rgb565
  import bmprgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // stream_byte
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // error_code, color, column, row, image_width,
                                  // image_height, zero fill
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast   // image_complete
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  result_t    out_res_r;
  logic       advance;
  logic       dec_valid;
  result_t    dec_res;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  bmprgb_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .stream_byte   (s1_byte_r),
    .end_of_stream (s1_last_r),
    .res_valid     (dec_valid),
    .res           (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) s1_valid_r <= 1'b1;
      else if (advance) s1_valid_r <= 1'b0;
      if (advance) out_valid_r <= dec_valid;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (advance && dec_valid) out_res_r <= dec_res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.data;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.image_complete;

endmodule

>>> rtl/bmprgb_checker.sv
// port-level checks for the bmp decoder, bound to the top level
`timescale 1ns / 1ps
module bmprgb_checker
  import bmprgb_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  out_data_t od;
  assign od = out_tdata;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // only error results carry an error code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_ERROR |-> od.error_code == ERR_NONE)
    else $error("error code on a non-error result");

  // image complete only flags a pixel result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_PIXEL)
    else $error("image complete on a non-pixel result");

  // a finished image has a size
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_DONE || out_tlast) |->
      od.image_width != 13'd0 && od.image_height != 13'd0)
    else $error("finished image without size");

  // a result follows an accepted byte
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2) || $past(!in_tready, 1))
    else $error("result without a byte");

endmodule

bind bmp_stream_to_rgb565 bmprgb_checker u_bmprgb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
